[hdl/indexed_ordered_list_defines.svh]
// Assertion macros used by the RTL top level.
`ifndef INDEXED_ORDERED_LIST_DEFINES_SVH
`define INDEXED_ORDERED_LIST_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every edge outside reset.
`define IOL_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");

// Antecedent at one edge implies consequent at the next.
`define IOL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define IOL_ASSERT_ALWAYS(label, clk, rstn, expr)
`define IOL_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

[hdl/iol_pkg.sv]
`default_nettype none

package iol_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int CMD_W        = 3;
    localparam int ST_W         = 2;

    localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REM_HEAD = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REM_TAIL = 3'd5;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [DATA_W-1:0]  value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[hdl/iol_cell.sv]
`default_nettype none

module iol_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  wire                       aclk,
    input  wire  iol_pkg::cell_ctrl_t ctrl,
    input  wire  [CNT_W-1:0]          pos,
    input  wire  [iol_pkg::DATA_W-1:0] left_data,
    input  wire  [iol_pkg::DATA_W-1:0] right_data,
    output logic [iol_pkg::DATA_W-1:0] slot_data
);
    import iol_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [DATA_W-1:0] slot_reg;
    logic [DATA_W-1:0] slot_next;

    always_comb begin
        slot_next = slot_reg;
        case (ctrl.op)
            CELL_INSERT: begin
                if (MY_IDX == pos) begin
                    slot_next = ctrl.value;
                end else if (MY_IDX > pos) begin
                    slot_next = left_data;
                end
            end
            CELL_REMOVE: begin
                slot_next = right_data;
            end
            default: begin
                slot_next = slot_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    assign slot_data = slot_reg;

endmodule

`default_nettype wire

[hdl/indexed_ordered_list.sv]
// Bounded ordered list of signed 32-bit values, position 0 first.
// Input channel (s_valid/s_ready): s_cmd, s_position, s_item_value. One
// request inserts at head, tail or a position, reads a position, or removes
// the head or the tail.
// Result channel (m_valid/m_ready): m_status, m_read_value and
// m_element_count, one result for every request.
// The result is registered at the edge that accepts the request. One
// request is taken per cycle while the receiver takes results; each cell
// of the chain shifts or holds its own slot in that cycle and the fill
// count updates alongside.
// If the receiver stalls, the result register holds and s_ready drops
// until it is taken; a request is still taken in the cycle the result
// leaves.
// Synchronous active-low reset empties the list and clears the result
// valid flag. Slot contents are not reset; only positions below the count
// are ever read.
`default_nettype none
`include "indexed_ordered_list_defines.svh"

module indexed_ordered_list #(
    parameter int CAPACITY = iol_pkg::CAPACITY_DEF,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [iol_pkg::CMD_W-1:0]    s_cmd,
    input  wire  [CNT_W-1:0]             s_position,
    input  wire  signed [iol_pkg::DATA_W-1:0] s_item_value,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [iol_pkg::ST_W-1:0]     m_status,
    output logic signed [iol_pkg::DATA_W-1:0] m_read_value,
    output logic [CNT_W-1:0]             m_element_count
);
    import iol_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [DATA_W-1:0] slot_data [CAPACITY];
    cell_ctrl_t        cell_ctrl;
    logic [CNT_W-1:0]  cell_pos;

    logic              accept;
    logic              full;
    logic              empty;
    logic [ST_W-1:0]   status_next;
    logic [DATA_W-1:0] rd_next;
    logic [CNT_W-1:0]  count_next;

    logic              m_valid_reg;
    logic [ST_W-1:0]   status_reg;
    logic [DATA_W-1:0] rd_reg;
    logic [CNT_W-1:0]  count_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CAP_CNT);
    assign empty   = (count_reg == '0);

    always_comb begin
        status_next     = ST_OK;
        rd_next         = '0;
        count_next      = count_reg;
        cell_ctrl.op    = CELL_HOLD;
        cell_ctrl.value = s_item_value;
        cell_pos        = s_position;
        case (s_cmd)
            CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
                if (s_cmd == CMD_INS_HEAD) begin
                    cell_pos = '0;
                end else if (s_cmd == CMD_INS_TAIL) begin
                    cell_pos = count_reg;
                end
                if (s_cmd == CMD_INS_POS && s_position > count_reg) begin
                    status_next = ST_INVALID;
                end else if (full) begin
                    status_next = ST_FULL;
                end else begin
                    cell_ctrl.op = CELL_INSERT;
                    count_next   = count_reg + CNT_W'(1);
                end
            end
            CMD_READ: begin
                if (s_position >= count_reg) begin
                    status_next = ST_INVALID;
                end else begin
                    rd_next = slot_data[s_position[IDX_W-1:0]];
                end
            end
            CMD_REM_HEAD, CMD_REM_TAIL: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    // tail removal only drops the count; no cell moves
                    if (s_cmd == CMD_REM_HEAD) begin
                        cell_ctrl.op = CELL_REMOVE;
                    end
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: begin
                status_next = ST_INVALID;
            end
        endcase
        if (!accept) begin
            cell_ctrl.op = CELL_HOLD;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;

        if (i == 0) begin : g_first
            assign left_d = s_item_value;
        end else begin : g_mid_l
            assign left_d = slot_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_d = slot_data[i];
        end else begin : g_mid_r
            assign right_d = slot_data[i+1];
        end

        iol_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl),
            .pos        (cell_pos),
            .left_data  (left_d),
            .right_data (right_d),
            .slot_data  (slot_data[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            if (accept) begin
                m_valid_reg <= 1'b1;
                count_reg   <= count_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            rd_reg     <= rd_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_read_value    = rd_reg;
    assign m_element_count = count_reg;

    `IOL_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CAP_CNT)
    `IOL_ASSERT_NEXT(a_count_stable, aclk, aresetn, !accept, $stable(count_reg))
    `IOL_ASSERT_ALWAYS(a_empty_count, aclk, aresetn,
        !(m_valid_reg && status_reg == ST_EMPTY) || count_reg == '0)
    `IOL_ASSERT_ALWAYS(a_read_ok, aclk, aresetn,
        !(m_valid_reg && rd_reg != '0) || status_reg == ST_OK)

endmodule

`default_nettype wire

[dv/indexed_ordered_list_tb.sv]
`timescale 1ns / 100ps

module indexed_ordered_list_tb;
    import iol_pkg::*;

    localparam int LIST_DEPTH  = CAPACITY_DEF;
    localparam int POS_MAX     = LIST_DEPTH;
    localparam int PHASE_ITEMS = 263;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 8;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [DATA_W-1:0] read_value;
        logic [4:0]        elem_count;
    } list_result_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [4:0]        pos;
        logic [DATA_W-1:0] value;
        logic [4:0]        reps;
        logic              exact;
        list_result_t      typed;
    } dir_row_t;

    typedef enum logic [1:0] {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } burst_mode_t;

    logic              aclk            = 1'b0;
    logic              aresetn         = 1'b0;
    logic              s_valid         = 1'b0;
    logic              s_ready;
    logic [CMD_W-1:0]  s_cmd           = CMD_INS_HEAD;
    logic [4:0]        s_position      = '0;
    logic [DATA_W-1:0] s_item_value    = '0;
    logic              m_valid;
    logic              m_ready         = 1'b0;
    logic [ST_W-1:0]   m_status;
    logic [DATA_W-1:0] m_read_value;
    logic [4:0]        m_element_count;

    logic [DATA_W-1:0] shadow_slots [LIST_DEPTH];
    int                shadow_count;
    list_result_t      pending_results [$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  cycle_count    = 0;
    bit  failed         = 1'b0;

    logic [CMD_W-1:0]  ins_cmds [3]   = '{CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS};
    logic [CMD_W-1:0]  rem_cmds [2]   = '{CMD_REM_HEAD, CMD_REM_TAIL};
    logic [DATA_W-1:0] edge_values [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};

    // Directed sweep: empty list, lone-element tail removal, extremes, full list.
    dir_row_t directed_rows [16] = '{
        '{CMD_READ,     5'd0,  32'h0,         5'd1,  1'b1, '{ST_INVALID, 32'h0, 5'd0}},
        '{CMD_REM_HEAD, 5'd0,  32'h0,         5'd1,  1'b1, '{ST_EMPTY,   32'h0, 5'd0}},
        '{CMD_REM_TAIL, 5'd0,  32'h0,         5'd1,  1'b1, '{ST_EMPTY,   32'h0, 5'd0}},
        '{CMD_INS_POS,  5'd1,  32'h1234_5678, 5'd1,  1'b1, '{ST_INVALID, 32'h0, 5'd0}},
        '{CMD_INS_HEAD, 5'd0,  32'h8000_0000, 5'd1,  1'b1, '{ST_OK,      32'h0, 5'd1}},
        '{CMD_REM_TAIL, 5'd0,  32'h0,         5'd1,  1'b1, '{ST_OK,      32'h0, 5'd0}},
        '{CMD_INS_POS,  5'd0,  32'h8000_0000, 5'd1,  1'b1, '{ST_OK,      32'h0, 5'd1}},
        '{CMD_INS_TAIL, 5'd31, 32'h7fff_ffff, 5'd1,  1'b1, '{ST_OK,      32'h0, 5'd2}},
        '{CMD_READ,     5'd0,  32'h0,         5'd1,  1'b1, '{ST_OK, 32'h8000_0000, 5'd2}},
        '{CMD_READ,     5'd2,  32'h0,         5'd1,  1'b1, '{ST_INVALID, 32'h0, 5'd2}},
        '{CMD_INS_POS,  5'd1,  32'hffff_ffff, 5'd1,  1'b1, '{ST_OK,      32'h0, 5'd3}},
        '{CMD_REM_HEAD, 5'd0,  32'h0,         5'd1,  1'b0, '0},
        '{CMD_INS_TAIL, 5'd0,  32'h5a5a_5a50, 5'd14, 1'b0, '0},
        '{CMD_INS_HEAD, 5'd0,  32'h0000_0001, 5'd1,  1'b1, '{ST_FULL,    32'h0, 5'd16}},
        '{CMD_INS_POS,  5'd16, 32'h0000_0002, 5'd1,  1'b1, '{ST_FULL,    32'h0, 5'd16}},
        '{CMD_READ,     5'd16, 32'h0,         5'd1,  1'b1, '{ST_INVALID, 32'h0, 5'd16}}
    };

    indexed_ordered_list u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_position      (s_position),
        .s_item_value    (s_item_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_read_value    (m_read_value),
        .m_element_count (m_element_count)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void shadow_insert(input int pos, input logic [DATA_W-1:0] value);
        for (int i = shadow_count; i > pos; i--)
            shadow_slots[i] = shadow_slots[i-1];
        shadow_slots[pos] = value;
        shadow_count++;
    endfunction

    function automatic void shadow_remove(input int pos);
        for (int i = pos; i + 1 < shadow_count; i++)
            shadow_slots[i] = shadow_slots[i+1];
        shadow_count--;
    endfunction

    // Applies one request to the shadow list and returns the result it should give.
    function automatic list_result_t list_apply(input logic [CMD_W-1:0] cmd,
                                                input logic [4:0] pos,
                                                input logic [DATA_W-1:0] value);
        list_result_t r;
        r.status     = ST_OK;
        r.read_value = '0;
        case (cmd)
            CMD_INS_HEAD: begin
                if (shadow_count >= LIST_DEPTH) r.status = ST_FULL;
                else shadow_insert(0, value);
            end
            CMD_INS_TAIL: begin
                if (shadow_count >= LIST_DEPTH) r.status = ST_FULL;
                else shadow_insert(shadow_count, value);
            end
            CMD_INS_POS: begin
                // position check takes priority over the full check
                if (int'(pos) > shadow_count) r.status = ST_INVALID;
                else if (shadow_count >= LIST_DEPTH) r.status = ST_FULL;
                else shadow_insert(int'(pos), value);
            end
            CMD_READ: begin
                if (int'(pos) >= shadow_count) r.status = ST_INVALID;
                else r.read_value = shadow_slots[pos];
            end
            CMD_REM_HEAD: begin
                if (shadow_count == 0) r.status = ST_EMPTY;
                else shadow_remove(0);
            end
            CMD_REM_TAIL: begin
                if (shadow_count == 0) r.status = ST_EMPTY;
                else shadow_remove(shadow_count - 1);
            end
            default: r.status = ST_INVALID;
        endcase
        r.elem_count = 5'(shadow_count);
        return r;
    endfunction

    // Presents one request after a random gap and waits for it to be taken.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [4:0] pos,
                                input logic [DATA_W-1:0] value, input logic exact,
                                input list_result_t typed);
        int gap;
        list_result_t predicted;
        gap = 0;
        while (gap < 64 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_position   <= pos;
        s_item_value <= value;
        do @(posedge aclk); while (!s_ready);
        predicted = list_apply(cmd, pos, value);
        pending_results.push_back(exact ? typed : predicted);
    endtask

    // Result side: random back-pressure and in-order comparison.
    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: status %0d count %0d",
                       m_status, m_element_count);
                failed <= 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    failed <= 1'b1;
                end
                if (m_read_value !== want.read_value) begin
                    $error("read_value: expected %h, got %h", want.read_value, m_read_value);
                    failed <= 1'b1;
                end
                if (m_element_count !== want.elem_count) begin
                    $error("element_count: expected %0d, got %0d",
                           want.elem_count, m_element_count);
                    failed <= 1'b1;
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic [CMD_W-1:0]  cmd;
        logic [4:0]        pos;
        logic [DATA_W-1:0] value;
        burst_mode_t       mode;
        int                burst_left;
        int                ins_pct;
        int                rem_pct;
        int                roll;
        int                idle_send [4];
        int                idle_recv [4];

        idle_send = '{0, 76, 0, 28};
        idle_recv = '{0, 0, 76, 28};
        shadow_count = 0;
        foreach (shadow_slots[i]) shadow_slots[i] = '0;
        mode       = MODE_FILL;
        burst_left = 0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            for (int k = 0; k < directed_rows[r].reps; k++)
                send_request(directed_rows[r].cmd, directed_rows[r].pos,
                             directed_rows[r].value + DATA_W'(k),
                             directed_rows[r].exact, directed_rows[r].typed);
        end

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_send[ph];
            recv_stall_pct = idle_recv[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(10, 40);
                    roll = $urandom_range(0, 2);
                    mode = (roll == 0) ? MODE_FILL : (roll == 1) ? MODE_DRAIN : MODE_MIX;
                end
                burst_left--;
                case (mode)
                    MODE_FILL:  begin ins_pct = 65; rem_pct = 15; end
                    MODE_DRAIN: begin ins_pct = 15; rem_pct = 65; end
                    default:    begin ins_pct = 35; rem_pct = 35; end
                endcase

                value = ($urandom_range(0, 7) == 0) ? edge_values[$urandom_range(0, 3)]
                                                    : DATA_W'($urandom());
                pos   = 5'($urandom_range(0, POS_MAX));
                roll  = $urandom_range(0, 99);
                if (roll < ins_pct) begin
                    cmd = ins_cmds[$urandom_range(0, 2)];
                    // mostly legal positions, some past the end
                    if ($urandom_range(0, 9) != 0)
                        pos = 5'($urandom_range(0, shadow_count));
                end else if (roll < ins_pct + rem_pct) begin
                    cmd = rem_cmds[$urandom_range(0, 1)];
                end else begin
                    cmd = CMD_READ;
                    if (shadow_count > 0 && $urandom_range(0, 9) != 0)
                        pos = 5'($urandom_range(0, shadow_count - 1));
                end
                send_request(cmd, pos, value, 1'b0, '0);
            end
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (!failed && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
